// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ----- hdl/lms_anc_pkg.sv -----
package lms_anc_pkg;

   localparam int TAP_COUNT_DEF = 5;
   localparam int SAMPLE_W      = 16;
   localparam int STEP_W        = 15;
   localparam logic [STEP_W-1:0] STEP_RESET = 15'd164;

   // Microprogram counter width; the program fills all eight steps.
   localparam int USTEP_W = 3;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,   // no datapath issue
      OP_MAC  = 2'd1,   // filter multiply-accumulate for one tap
      OP_UPD  = 2'd2,   // weight update for one tap
      OP_MUE  = 2'd3    // form mu times error
   } op_type;

   typedef enum logic [2:0] {
      JMP_NEXT     = 3'd0,  // fall through to the next step
      JMP_LOOP     = 3'd1,  // repeat until the last tap has been issued
      JMP_WAIT_IN  = 3'd2,  // hold until an input word arrives
      JMP_WAIT_OUT = 3'd3,  // hold until the output register is free
      JMP_START    = 3'd4   // return to the first step
   } jmp_type;

   typedef struct packed {
      jmp_type jmp;
      op_type  op;
      logic    err_ld;
   } ucode_type;

   // Control word handed from the sequencer to the datapath.
   typedef struct packed {
      logic   in_rdy;
      logic   accept;
      op_type op;
      logic   err_ld;
   } seq_ctrl_type;

   // Conditions the sequencer branches on.
   typedef struct packed {
      logic req_valid;
      logic rsp_free;
      logic last_tap;
   } seq_stat_type;

   // The control program.
   function automatic ucode_type ucode_rom(input logic [USTEP_W-1:0] step);
      ucode_type w;
      w = '{jmp: JMP_NEXT, op: OP_NONE, err_ld: 1'b0};
      case (step)
         3'd0: w = '{jmp: JMP_WAIT_IN,  op: OP_NONE, err_ld: 1'b0};
         3'd1: w = '{jmp: JMP_LOOP,     op: OP_MAC,  err_ld: 1'b0};
         3'd2: w = '{jmp: JMP_NEXT,     op: OP_NONE, err_ld: 1'b0};
         3'd3: w = '{jmp: JMP_NEXT,     op: OP_NONE, err_ld: 1'b0};
         3'd4: w = '{jmp: JMP_WAIT_OUT, op: OP_MUE,  err_ld: 1'b1};
         3'd5: w = '{jmp: JMP_NEXT,     op: OP_NONE, err_ld: 1'b0};
         3'd6: w = '{jmp: JMP_LOOP,     op: OP_UPD,  err_ld: 1'b0};
         3'd7: w = '{jmp: JMP_START,    op: OP_NONE, err_ld: 1'b0};
         default: w = '{jmp: JMP_START, op: OP_NONE, err_ld: 1'b0};
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/lms_anc_ram.sv -----
module lms_anc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lms_anc_seq.sv -----
module lms_anc_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  lms_anc_pkg::seq_stat_type   stat,
   output lms_anc_pkg::seq_ctrl_type   ctrl
);

   logic [lms_anc_pkg::USTEP_W-1:0] step_ff, step_in;
   lms_anc_pkg::ucode_type          word;
   logic                            go;

   assign word = lms_anc_pkg::ucode_rom(step_ff);

   always_comb begin
      go      = 1'b1;
      step_in = step_ff;
      case (word.jmp)
         lms_anc_pkg::JMP_NEXT: begin
            step_in = step_ff + 1'b1;
         end
         lms_anc_pkg::JMP_LOOP: begin
            step_in = stat.last_tap ? step_ff + 1'b1 : step_ff;
         end
         lms_anc_pkg::JMP_WAIT_IN: begin
            go      = stat.req_valid;
            step_in = go ? step_ff + 1'b1 : step_ff;
         end
         lms_anc_pkg::JMP_WAIT_OUT: begin
            go      = stat.rsp_free;
            step_in = go ? step_ff + 1'b1 : step_ff;
         end
         lms_anc_pkg::JMP_START: begin
            step_in = '0;
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   // No input word is taken while reset is held.
   always_comb begin
      ctrl.in_rdy = !reset && (word.jmp == lms_anc_pkg::JMP_WAIT_IN);
      ctrl.accept = ctrl.in_rdy && go;
      ctrl.op     = go ? word.op : lms_anc_pkg::OP_NONE;
      ctrl.err_ld = go && word.err_ld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ----- hdl/lms_anc_dp.sv -----
module lms_anc_dp #(
   parameter int TAP_COUNT = lms_anc_pkg::TAP_COUNT_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lms_anc_pkg::seq_ctrl_type               ctrl,
   input  logic signed [lms_anc_pkg::SAMPLE_W-1:0] primary_sample,
   input  logic signed [lms_anc_pkg::SAMPLE_W-1:0] reference_sample,
   input  logic [lms_anc_pkg::STEP_W-1:0]          step_size,
   output logic                                    last_tap,
   output logic signed [lms_anc_pkg::SAMPLE_W-1:0] error_sample
);

   localparam int IW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
   localparam logic [IW-1:0] LAST = IW'(TAP_COUNT - 1);

   typedef struct packed {
      lms_anc_pkg::op_type op;
      logic                hvld;
      logic                wvld;
      logic [IW-1:0]       idx;
   } tag_type;

   logic [IW-1:0]        head_ff, head_in, ptr_ff, ptr_in, idx_ff, idx_in;
   logic [TAP_COUNT-1:0] hist_vld_ff, hist_vld_in, wt_vld_ff, wt_vld_in;
   tag_type              p1_ff, p1_in, p2_ff;
   logic                 issue;

   logic signed [15:0] prim_ff, err_ff, w_p2_ff;
   logic signed [31:0] acc_ff, mu_err_ff;
   logic signed [47:0] prod_ff, prod_in;
   logic signed [31:0] op_a;
   logic signed [15:0] op_b, hist_rd, wt_rd, x_val, w_val, new_w;
   logic               wt_we;

   assign issue    = (ctrl.op == lms_anc_pkg::OP_MAC) || (ctrl.op == lms_anc_pkg::OP_UPD);
   assign last_tap = (idx_ff == LAST);
   assign head_in  = (head_ff == LAST) ? '0 : head_ff + 1'b1;

   // Tap index and circular history pointer walk together, newest sample first.
   always_comb begin
      ptr_in      = ptr_ff;
      idx_in      = idx_ff;
      hist_vld_in = hist_vld_ff;
      if (ctrl.accept) begin
         ptr_in               = head_in;
         hist_vld_in[head_in] = 1'b1;
      end else if (issue) begin
         ptr_in = (ptr_ff == '0) ? LAST : ptr_ff - 1'b1;
         idx_in = last_tap ? '0 : idx_ff + 1'b1;
      end
   end

   always_comb begin
      p1_in.op   = ctrl.op;
      p1_in.hvld = hist_vld_ff[ptr_ff];
      p1_in.wvld = wt_vld_ff[idx_ff];
      p1_in.idx  = idx_ff;
   end

   lms_anc_ram #(.WIDTH(lms_anc_pkg::SAMPLE_W), .DEPTH(TAP_COUNT)) u_hist (
      .clock   (clock),
      .wr_en   (ctrl.accept),
      .wr_addr (head_in),
      .wr_data (reference_sample),
      .rd_addr (ptr_ff),
      .rd_data (hist_rd)
   );

   lms_anc_ram #(.WIDTH(lms_anc_pkg::SAMPLE_W), .DEPTH(TAP_COUNT)) u_wt (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (p2_ff.idx),
      .wr_data (new_w),
      .rd_addr (idx_ff),
      .rd_data (wt_rd)
   );

   // Entries never written read as zero.
   assign x_val = p1_ff.hvld ? hist_rd : 16'sd0;
   assign w_val = p1_ff.wvld ? wt_rd : 16'sd0;

   // The one shared multiplier.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (p1_ff.op)
         lms_anc_pkg::OP_MAC: begin
            op_a = 32'(w_val);
            op_b = x_val;
         end
         lms_anc_pkg::OP_UPD: begin
            op_a = mu_err_ff;
            op_b = x_val;
         end
         lms_anc_pkg::OP_MUE: begin
            op_a = $signed({17'd0, step_size});
            op_b = err_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = 48'(op_a) * 48'(op_b);

   // Only bits 30:15 of the tap sum survive, so a 32-bit wrapping sum is exact enough.
   assign error_sample = prim_ff - acc_ff[30:15];
   assign wt_we        = (p2_ff.op == lms_anc_pkg::OP_UPD);
   assign new_w        = w_p2_ff + prod_ff[45:30];

   always_comb begin
      wt_vld_in = wt_vld_ff;
      if (wt_we) begin
         wt_vld_in[p2_ff.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         ptr_ff      <= '0;
         idx_ff      <= '0;
         hist_vld_ff <= '0;
         wt_vld_ff   <= '0;
         p1_ff       <= '{op: lms_anc_pkg::OP_NONE, hvld: 1'b0, wvld: 1'b0, idx: '0};
         p2_ff       <= '{op: lms_anc_pkg::OP_NONE, hvld: 1'b0, wvld: 1'b0, idx: '0};
      end else begin
         if (ctrl.accept) begin
            head_ff <= head_in;
         end
         ptr_ff      <= ptr_in;
         idx_ff      <= idx_in;
         hist_vld_ff <= hist_vld_in;
         wt_vld_ff   <= wt_vld_in;
         p1_ff       <= p1_in;
         p2_ff       <= p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      w_p2_ff <= w_val;
      if (ctrl.accept) begin
         prim_ff <= primary_sample;
         acc_ff  <= '0;
      end else if (p2_ff.op == lms_anc_pkg::OP_MAC) begin
         acc_ff <= acc_ff + prod_ff[31:0];
      end
      if (p2_ff.op == lms_anc_pkg::OP_MUE) begin
         mu_err_ff <= prod_ff[31:0];
      end
      if (ctrl.err_ld) begin
         err_ff <= error_sample;
      end
   end

endmodule

// ----- hdl/lms_adaptive_noise_canceller.sv -----
// The block takes one word at a time: no new input word is taken until the weight
// updates of the previous word have been issued. The single multiplier serves
// TAP_COUNT filter products and TAP_COUNT weight updates in turn.
// Reset: synchronous, active high. Delay line and weights read as zero at once through
// per-entry valid bits (no clearing pass); step_size returns to 164.
`include "assert_macros.svh"

module lms_adaptive_noise_canceller #(
   parameter int TAP_COUNT = lms_anc_pkg::TAP_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] primary_sample, [31:16] reference_sample
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] error_sample
   // Step size register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [14:0] csr_data     // step_size, unsigned Q15
);

   // The control program runs one word at a time:
   //   step 0      wait for an input word, push the reference into the delay line
   //   step 1      one filter multiply-accumulate per tap, looping over all taps
   //   steps 2-3   let the multiplier and accumulator pipeline drain
   //   step 4      wait for a free output register, form the error, start mu * error
   //   step 5      let mu * error settle
   //   step 6      one weight update per tap, looping over all taps
   //   step 7      drain, which also keeps a single-tap filter from reading a stale weight
   // The result word sits in its own output register, so the next input word is taken
   // even while the previous error has not been collected downstream.

   lms_anc_pkg::seq_ctrl_type ctrl;
   lms_anc_pkg::seq_stat_type stat;

   logic [lms_anc_pkg::STEP_W-1:0] step_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [15:0]                    rsp_data_ff;
   logic signed [15:0]             err_val;
   logic                           last_tap;
   logic                           rsp_free;

   // The register write is taken whenever reset is released; software must only write
   // while the block is idle, which the block itself does not enforce.
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lms_anc_pkg::STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         step_ff <= csr_data;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      stat.req_valid = req_tvalid;
      stat.rsp_free  = rsp_free;
      stat.last_tap  = last_tap;
   end

   lms_anc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   lms_anc_dp #(.TAP_COUNT(TAP_COUNT)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .primary_sample   (req_tdata[15:0]),
      .reference_sample (req_tdata[31:16]),
      .step_size        (step_ff),
      .last_tap         (last_tap),
      .error_sample     (err_val)
   );

   assign req_tready = ctrl.in_rdy;

   // Output register: loaded when the error is formed, cleared once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.err_ld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.err_ld) begin
         rsp_data_ff <= err_val;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Once a word is taken, the sequencer must be busy with it in the next cycle.
   `ASSERT_CLK(a_one_item, clock, reset, req_tvalid && req_tready |=> !req_tready, "second word taken while busy")
   // A new error must never overwrite a result that is still waiting downstream.
   `ASSERT_NEVER(a_no_overwrite, clock, reset, ctrl.err_ld && rsp_valid_ff && !rsp_tready, "pending result overwritten")
   // The filter loop only ever starts from the tap counter's home position.
   `ASSERT_CLK(a_loop_home, clock, reset, ctrl.accept |=> !$past(last_tap) || TAP_COUNT == 1, "tap counter not at home on accept")

endmodule

// ----- verif/lms_anc_checker.sv -----
`timescale 1ns / 1ps

// Watches the sample, error and step size channels of the noise canceller.
// It keeps its own copy of the delay line, the weights and mu, and checks
// every error word against the oldest predicted one.
module lms_anc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] primary_sample, [31:16] reference_sample
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [15:0] error_sample
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [14:0] csr_data,    // step_size
   output int          mismatches,
   output int          outstanding
);

   localparam int TAPS         = lms_anc_pkg::TAP_COUNT_DEF;
   localparam int OUTPUT_SHIFT = 15;
   localparam int UPDATE_SHIFT = 30;

   logic signed [lms_anc_pkg::SAMPLE_W-1:0] ref_line [TAPS];
   logic signed [lms_anc_pkg::SAMPLE_W-1:0] weights  [TAPS];
   logic        [lms_anc_pkg::STEP_W-1:0]   mu;
   logic        [15:0]                       pending_errors [$];

   // Shifts the new reference in, filters, forms the error and adapts the weights.
   function automatic logic [15:0] cancel_sample(input logic signed [15:0] primary,
                                                 input logic signed [15:0] reference);
      longint             acc;
      longint             upd;
      logic signed [15:0] filtered;
      logic signed [15:0] err;
      for (int i = TAPS - 1; i > 0; i--) ref_line[i] = ref_line[i - 1];
      ref_line[0] = reference;
      acc = 0;
      for (int i = 0; i < TAPS; i++) acc += longint'(weights[i]) * longint'(ref_line[i]);
      acc      = acc >>> OUTPUT_SHIFT;
      filtered = acc[15:0];
      err      = primary - filtered;
      for (int i = 0; i < TAPS; i++) begin
         upd        = longint'(mu) * longint'(err) * longint'(ref_line[i]);
         upd        = upd >>> UPDATE_SHIFT;
         weights[i] = weights[i] + upd[15:0];
      end
      return err;
   endfunction

   initial mismatches = 0;

   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            ref_line[i] = '0;
            weights[i]  = '0;
         end
         mu = lms_anc_pkg::STEP_RESET;
         pending_errors.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_errors.size() == 0) begin
               $display("%0t: unexpected error word, expected none, got %0d",
                        $time, $signed(rsp_tdata));
               mismatches = mismatches + 1;
            end else begin
               want = pending_errors.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: error_sample mismatch, expected %0d, got %0d",
                           $time, $signed(want), $signed(rsp_tdata));
                  mismatches = mismatches + 1;
               end
            end
         end
         if (csr_valid && csr_ready) mu = csr_data;
         if (req_tvalid && req_tready)
            pending_errors.push_back(cancel_sample(req_tdata[15:0], req_tdata[31:16]));
      end
      outstanding <= pending_errors.size();
   end

endmodule

// ----- verif/tb_lms_adaptive_noise_canceller.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the LMS noise canceller. The checker beside the
// block does all prediction; this module only drives the three channels.
module tb_lms_adaptive_noise_canceller;

   // The weight update of a sample word can run on after its error word has
   // left, so the step size is only changed after a further quiet pause, long
   // enough for that update to finish.
   localparam int SETTLE_CYCLES = 2 * lms_anc_pkg::TAP_COUNT_DEF + 10;
   // The slowest run is roughly 500 words, each with a full idle gap, its work and
   // a full stall, plus the settling pauses; the limit is several times that.
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_WORDS  = 64;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [15:0] primary_sample, [31:16] reference_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;    // [15:0] error_sample
   logic        csr_valid;
   logic        csr_ready;
   logic [14:0] csr_data;     // step_size
   int          mismatches;
   int          outstanding;
   int          cycles = 0;
   int          rsp_stall = 0;
   // While steady is set neither side idles, so words go back to back.
   bit          steady = 1'b0;

   lms_adaptive_noise_canceller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   lms_anc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The watchdog ends a run that hangs.
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The error side draws a stall before taking each word. Unless that stall is
   // zero, ready drops right after a word is taken and rises again when it runs out.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = $urandom_range(0, 19);
      end else if (!rsp_tready) begin
         if (rsp_stall == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_stall = rsp_stall - 1;
         end
      end else if (rsp_tvalid) begin
         rsp_stall = steady ? 0 : $urandom_range(0, 19);
         if (rsp_stall != 0) begin
            rsp_tready <= 1'b0;
            rsp_stall = rsp_stall - 1;
         end
      end
   end

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 19);
   endfunction

   // Samples lean on the extremes and on small values, where the weights adapt
   // slowly and the floor of the shifts shows most.
   function automatic logic [15:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2, 3: return 16'($urandom_range(0, 512) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   // Valid stays high after a word is taken, so that a word with no gap
   // follows at once; it is lowered only for a drawn gap or by settle().
   task automatic send_word(input logic [15:0] primary, input logic [15:0] reference);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {reference, primary};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops the sample stream and waits until every error word has come back
   // and the last weight update has had time to finish.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_step_size(input logic [14:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [14:0] step_plan [7];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      step_plan  = '{15'd0, 15'd32767, 15'd1, 15'd164, 15'($urandom),
                     15'd16384, 15'($urandom)};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset step size: zero, both extremes on both
      // inputs, unit values of either sign and one mid-range primary.
      send_word(16'h0000, 16'h0000);
      send_word(16'h7FFF, 16'h7FFF);
      send_word(16'h8000, 16'h8000);
      send_word(16'h7FFF, 16'h8000);
      send_word(16'h8000, 16'h7FFF);
      send_word(16'h0001, 16'hFFFF);
      send_word(16'hFFFF, 16'h0001);
      send_word(16'h0000, 16'h7FFF);
      send_word(16'h3039, 16'h8000);
      send_word(16'h8000, 16'h8000);
      send_word(16'h7FFF, 16'h7FFF);
      send_word(16'h0000, 16'h0000);

      // With the largest step the weights swing to full scale at once, so the
      // tap sum runs far past 16 bits and both the weights and the error wrap.
      settle();
      write_step_size(15'd32767);
      send_word(16'h7FFF, 16'h7FFF);
      send_word(16'h7FFF, 16'h7FFF);
      send_word(16'h7FFF, 16'h7FFF);
      send_word(16'h8000, 16'h8000);
      send_word(16'h8000, 16'h8000);
      send_word(16'h8000, 16'h8000);
      send_word(16'h7FFF, 16'h8000);
      send_word(16'h8000, 16'h7FFF);
      send_word(16'hFFFF, 16'h8000);
      send_word(16'h0000, 16'h7FFF);

      // Random words under a range of step sizes. Each change of step size
      // also makes the sender wait until every error word has come back.
      foreach (step_plan[p]) begin
         settle();
         write_step_size(step_plan[p]);
         for (int n = 0; n < RANDOM_WORDS; n++) begin
            send_word(draw_sample(), draw_sample());
            if ($urandom_range(0, 31) == 0) steady = !steady;
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
